/* rtl/core/sprite_quad_corner_generator_core_macros.svh */
// Assertion macros used by the sprite quad corner generator RTL.
`ifndef SPRITE_QUAD_CORNER_GENERATOR_CORE_MACROS_SVH
`define SPRITE_QUAD_CORNER_GENERATOR_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define SQCG_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sqcg assertion failed");
`define SQCG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sqcg assertion failed");
`else
`define SQCG_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define SQCG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/core/sqcg_pkg.sv */
// Types and constants shared by the sprite quad corner generator.
`default_nettype none
package sqcg_pkg;

    localparam int COORD_W = 32;
    localparam int TRIG_W = 16;
    localparam int TRIG_FRAC = 14;
    localparam int ANCHOR_W = 4;
    localparam int POS_W = COORD_W + 1;
    localparam int MUL_W = COORD_W + TRIG_W;
    localparam int PROD_W = MUL_W - TRIG_FRAC;
    localparam int WIDE_W = COORD_W + 4;

    localparam logic [ANCHOR_W-1:0] ANCHOR_CENTER = 4'd0;
    localparam logic [ANCHOR_W-1:0] ANCHOR_TL = 4'd1;
    localparam logic [ANCHOR_W-1:0] ANCHOR_TC = 4'd2;
    localparam logic [ANCHOR_W-1:0] ANCHOR_TR = 4'd3;
    localparam logic [ANCHOR_W-1:0] ANCHOR_CL = 4'd4;
    localparam logic [ANCHOR_W-1:0] ANCHOR_CR = 4'd5;
    localparam logic [ANCHOR_W-1:0] ANCHOR_BL = 4'd6;
    localparam logic [ANCHOR_W-1:0] ANCHOR_BC = 4'd7;
    localparam logic [ANCHOR_W-1:0] ANCHOR_BR = 4'd8;

    localparam logic REG_DRAW_ANCHOR = 1'b0;
    localparam logic REG_ROTATE_ANCHOR = 1'b1;

    typedef struct packed {
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] half_width;
        logic signed [COORD_W-1:0] half_height;
        logic signed [TRIG_W-1:0]  sin_val;
        logic signed [TRIG_W-1:0]  cos_val;
        logic                      rotated;
    } in_beat_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] corner1_x;
        logic signed [COORD_W-1:0] corner1_y;
        logic signed [COORD_W-1:0] corner2_x;
        logic signed [COORD_W-1:0] corner2_y;
        logic signed [COORD_W-1:0] corner3_x;
        logic signed [COORD_W-1:0] corner3_y;
        logic signed [COORD_W-1:0] corner4_x;
        logic signed [COORD_W-1:0] corner4_y;
    } out_beat_t;

    // Anchored position and the four rounded products of one sprite.
    typedef struct packed {
        logic signed [POS_W-1:0]   x;
        logic signed [POS_W-1:0]   y;
        logic signed [COORD_W-1:0] hw;
        logic signed [COORD_W-1:0] hh;
        logic signed [PROD_W-1:0]  cw;
        logic signed [PROD_W-1:0]  sw;
        logic signed [PROD_W-1:0]  sh;
        logic signed [PROD_W-1:0]  ch;
        logic                      rot;
    } mid_t;

endpackage
`default_nettype wire

/* rtl/core/sqcg_corner.sv */
// Rotation pivot offset, corner sums and output saturation.
`default_nettype none
module sqcg_corner (
    input  wire sqcg_pkg::mid_t                  mid,
    input  wire logic [sqcg_pkg::ANCHOR_W-1:0]   rotate_anchor,
    output sqcg_pkg::out_beat_t                  corners
);
    import sqcg_pkg::*;

    function automatic logic signed [COORD_W-1:0] sat(input logic signed [WIDE_W-1:0] v);
        logic signed [COORD_W-1:0] res;
        if (v > WIDE_W'(signed'({1'b0, {(COORD_W-1){1'b1}}})))
        begin
            res = {1'b0, {(COORD_W-1){1'b1}}};
        end
        else if (v < WIDE_W'(signed'({1'b1, {(COORD_W-1){1'b0}}})))
        begin
            res = {1'b1, {(COORD_W-1){1'b0}}};
        end
        else
        begin
            res = v[COORD_W-1:0];
        end
        return res;
    endfunction

    logic signed [WIDE_W-1:0] x;
    logic signed [WIDE_W-1:0] y;
    logic signed [WIDE_W-1:0] hw;
    logic signed [WIDE_W-1:0] hh;
    logic signed [WIDE_W-1:0] cw;
    logic signed [WIDE_W-1:0] sw;
    logic signed [WIDE_W-1:0] sh;
    logic signed [WIDE_W-1:0] ch;
    logic signed [WIDE_W-1:0] dx;
    logic signed [WIDE_W-1:0] dy;

    assign x = WIDE_W'(mid.x);
    assign y = WIDE_W'(mid.y);
    assign hw = WIDE_W'(mid.hw);
    assign hh = WIDE_W'(mid.hh);
    assign cw = WIDE_W'(mid.cw);
    assign sw = WIDE_W'(mid.sw);
    assign sh = WIDE_W'(mid.sh);
    assign ch = WIDE_W'(mid.ch);

    always_comb
    begin
        dx = '0;
        dy = '0;
        if (mid.rot)
        begin
            case (rotate_anchor)
                ANCHOR_TL:
                begin
                    dx = cw + sh - hw;
                    dy = hh + sw - ch;
                end
                ANCHOR_TC:
                begin
                    dx = sh;
                    dy = hh - ch;
                end
                ANCHOR_TR:
                begin
                    dx = hw - cw + sh;
                    dy = hh - sw - ch;
                end
                ANCHOR_CL:
                begin
                    dx = cw - hw;
                    dy = sw;
                end
                ANCHOR_CR:
                begin
                    dx = hw - cw;
                    dy = -sw;
                end
                ANCHOR_BL:
                begin
                    dx = cw - hw - sh;
                    dy = sw + ch - hh;
                end
                ANCHOR_BC:
                begin
                    dx = -sh;
                    dy = ch - hh;
                end
                ANCHOR_BR:
                begin
                    dx = hw - cw - sh;
                    dy = ch - hh - sw;
                end
                default:
                begin
                    dx = '0;
                    dy = '0;
                end
            endcase
        end
    end

    // With the rotated flag clear, the products carry the plain half sizes.
    assign corners.corner1_x = sat(x + dx - cw + sh);
    assign corners.corner1_y = sat(y + dy - sw - ch);
    assign corners.corner2_x = sat(x + dx + cw + sh);
    assign corners.corner2_y = sat(y + dy + sw - ch);
    assign corners.corner3_x = sat(x + dx - cw - sh);
    assign corners.corner3_y = sat(y + dy - sw + ch);
    assign corners.corner4_x = sat(x + dx + cw - sh);
    assign corners.corner4_y = sat(y + dy + sw + ch);

endmodule
`default_nettype wire

/* rtl/core/sprite_quad_corner_generator_core.sv */
// Sprite quad corner generator: turns one sprite placement into four strip corners.
//
// One placement is accepted per cycle while the pipeline does not stall, and its four corners
// pass through the first and then the second register stage before they are offered on
// the output. The first register stage holds the anchored position and the four
// Q1.14 by Q16.16 products, the second holds the summed and saturated corners. Each stage
// only holds its beat when the stage after it is full and stalled, so an input beat is
// still taken while a finished result waits on the output as long as the first stage is
// empty. The anchor registers are written through the configuration channel, which is
// always ready.
`default_nettype none
`include "sprite_quad_corner_generator_core_macros.svh"
module sprite_quad_corner_generator_core (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire sqcg_pkg::in_beat_t                in_data,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output sqcg_pkg::out_beat_t                    out_data,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic                              cfg_index,
    input  wire logic [sqcg_pkg::ANCHOR_W-1:0]     cfg_data
);
    import sqcg_pkg::*;

    function automatic logic signed [PROD_W-1:0] trig_round(
        input logic signed [TRIG_W-1:0]  t,
        input logic signed [COORD_W-1:0] c
    );
        logic signed [MUL_W-1:0] p;
        p = MUL_W'(t) * MUL_W'(c) + MUL_W'(signed'({1'b0, 1'b1, {(TRIG_FRAC-1){1'b0}}}));
        return p[MUL_W-1:TRIG_FRAC];
    endfunction

    logic [ANCHOR_W-1:0] draw_anchor_reg;
    logic [ANCHOR_W-1:0] rotate_anchor_reg;
    logic                mid_valid_reg;
    mid_t                mid_reg;
    mid_t                mid_next;
    logic                out_valid_reg;
    out_beat_t           out_reg;
    out_beat_t           out_next;
    logic                out_free;
    logic                mid_move;
    logic                in_take;

    logic signed [POS_W-1:0] px;
    logic signed [POS_W-1:0] py;
    logic signed [POS_W-1:0] phw;
    logic signed [POS_W-1:0] phh;

    assign cfg_ready = 1'b1;
    assign out_free = !out_valid_reg || out_ready;
    assign mid_move = mid_valid_reg && out_free;
    assign in_ready = !mid_valid_reg || out_free;
    assign in_take = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data = out_reg;

    assign px = POS_W'(in_data.pos_x);
    assign py = POS_W'(in_data.pos_y);
    assign phw = POS_W'(in_data.half_width);
    assign phh = POS_W'(in_data.half_height);

    always_comb
    begin
        mid_next.x = px;
        mid_next.y = py;
        case (draw_anchor_reg)
            ANCHOR_TL:
            begin
                mid_next.x = px + phw;
                mid_next.y = py - phh;
            end
            ANCHOR_TC:
            begin
                mid_next.y = py - phh;
            end
            ANCHOR_TR:
            begin
                mid_next.x = px - phw;
                mid_next.y = py - phh;
            end
            ANCHOR_CL:
            begin
                mid_next.x = px + phw;
            end
            ANCHOR_CR:
            begin
                mid_next.x = px - phw;
            end
            ANCHOR_BL:
            begin
                mid_next.x = px + phw;
                mid_next.y = py + phh;
            end
            ANCHOR_BC:
            begin
                mid_next.y = py + phh;
            end
            ANCHOR_BR:
            begin
                mid_next.x = px - phw;
                mid_next.y = py + phh;
            end
            default:
            begin
                mid_next.x = px;
                mid_next.y = py;
            end
        endcase
        mid_next.hw = in_data.half_width;
        mid_next.hh = in_data.half_height;
        mid_next.rot = in_data.rotated;
        // An unrotated quad reuses the rotated corner sums with cos one and sin zero.
        if (in_data.rotated)
        begin
            mid_next.cw = trig_round(in_data.cos_val, in_data.half_width);
            mid_next.sw = trig_round(in_data.sin_val, in_data.half_width);
            mid_next.sh = trig_round(in_data.sin_val, in_data.half_height);
            mid_next.ch = trig_round(in_data.cos_val, in_data.half_height);
        end
        else
        begin
            mid_next.cw = PROD_W'(in_data.half_width);
            mid_next.sw = '0;
            mid_next.sh = '0;
            mid_next.ch = PROD_W'(in_data.half_height);
        end
    end

    sqcg_corner u_corner (
        .mid           (mid_reg),
        .rotate_anchor (rotate_anchor_reg),
        .corners       (out_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            draw_anchor_reg <= ANCHOR_BL;
            rotate_anchor_reg <= ANCHOR_CENTER;
            mid_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_DRAW_ANCHOR:   draw_anchor_reg <= cfg_data;
                    REG_ROTATE_ANCHOR: rotate_anchor_reg <= cfg_data;
                    default:           draw_anchor_reg <= draw_anchor_reg;
                endcase
            end
            if (in_ready)
            begin
                mid_valid_reg <= in_valid;
            end
            if (out_free)
            begin
                out_valid_reg <= mid_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            mid_reg <= mid_next;
        end
        if (mid_move)
        begin
            out_reg <= out_next;
        end
    end

    `SQCG_ASSERT_NEXT(a_take_fills_mid, clk, rst_n, in_take, mid_valid_reg)
    `SQCG_ASSERT_NEXT(a_mid_moves_out, clk, rst_n, mid_move, out_valid_reg)
    `SQCG_ASSERT_NEXT(a_mid_holds, clk, rst_n, mid_valid_reg && !out_free, mid_valid_reg && $stable(mid_reg))
    `SQCG_ASSERT_SAME(a_full_blocks_in, clk, rst_n, out_valid_reg && !out_ready && mid_valid_reg, !in_ready)

endmodule
`default_nettype wire
